### rtl/shbh_pkg.sv
package shbh_pkg;

  localparam int NUM_BINS = 500;

  // Bin index and address widths that follow from the bin count.
  localparam int BIN_W    = $clog2(NUM_BINS);
  localparam int SEC_DEPTH = 3 * NUM_BINS;
  localparam int SADDR_W  = $clog2(SEC_DEPTH);
  localparam int PROD_W   = 16 + $clog2(NUM_BINS + 1);

  // Fixed field widths of the channels.
  localparam int DET_W    = 8;
  localparam int VAL16_W  = 16;
  localparam int WEIGHT_W = 32;
  localparam int RBIN_W   = 9;
  localparam int ACC_W    = 48;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // Azimuth position within one seventh of a turn (8192 units).
  localparam int SEC_W = 13;
  localparam logic [SEC_W-1:0] SEC_EDGE_A = 13'd1024;
  localparam logic [SEC_W-1:0] SEC_EDGE_B = 13'd3072;
  localparam logic [SEC_W-1:0] SEC_EDGE_C = 13'd5120;
  localparam logic [SEC_W-1:0] SEC_EDGE_D = 13'd7168;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [1:0] HIST_TOTAL = 2'd0;

  localparam logic [1:0] SECTOR_CLOSED = 2'd0;
  localparam logic [1:0] SECTOR_TRANS  = 2'd1;
  localparam logic [1:0] SECTOR_OPEN   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DETECTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd2;

  localparam logic [DET_W-1:0]   DET_RESET    = 8'd28;
  localparam logic [VAL16_W-1:0] ENERGY_RESET = 16'd1000;
  localparam logic [VAL16_W-1:0] RADIUS_RESET = 16'd500;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  typedef struct packed {
    logic [DET_W-1:0]   detector_match;
    logic [VAL16_W-1:0] energy_minimum;
    logic [VAL16_W-1:0] radius_minimum;
  } cfg_t;

  // Everything the lookup cycle needs to know about the item in flight.
  typedef struct packed {
    logic                op;
    logic                pass;
    logic [1:0]          sector;
    logic [BIN_W-1:0]    bin;
    logic [RBIN_W-1:0]   read_bin;
    logic                range_ok;
    logic [1:0]          read_histogram;
    logic [WEIGHT_W-1:0] weight;
    logic [BIN_W-1:0]    taddr;
    logic [SADDR_W-1:0]  saddr;
  } ctx_t;

endpackage

### rtl/shbh_if.sv
interface shbh_hit_if;
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic [shbh_pkg::DET_W-1:0]     detector_number;
  logic [shbh_pkg::VAL16_W-1:0]   hit_energy;
  logic [shbh_pkg::VAL16_W-1:0]   hit_radius;
  logic signed [15:0]             hit_azimuth;
  logic [shbh_pkg::VAL16_W-1:0]   scatter_angle;
  logic [shbh_pkg::WEIGHT_W-1:0]  hit_weight;
  logic [shbh_pkg::RBIN_W-1:0]    read_bin;
  logic [1:0]                     read_histogram;

  modport source (output valid, op, detector_number, hit_energy, hit_radius, hit_azimuth,
                  scatter_angle, hit_weight, read_bin, read_histogram, input ready);
  modport sink (input valid, op, detector_number, hit_energy, hit_radius, hit_azimuth,
                scatter_angle, hit_weight, read_bin, read_histogram, output ready);
endinterface

interface shbh_res_if;
  logic                         valid;
  logic                         ready;
  logic                         accepted;
  logic [1:0]                   sector_class;
  logic [shbh_pkg::RBIN_W-1:0]  bin_number;
  logic [shbh_pkg::ACC_W-1:0]   bin_value;

  modport source (output valid, accepted, sector_class, bin_number, bin_value, input ready);
  modport sink (input valid, accepted, sector_class, bin_number, bin_value, output ready);
endinterface

interface shbh_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [shbh_pkg::CFG_IDX_W-1:0]  index;
  logic [shbh_pkg::CFG_DAT_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/sector_binned_hit_histogrammer_unit.sv
// Sector-binned hit histogrammer. Each hit item that matches the configured
// detector and exceeds the energy and radius minimums adds its weight, with
// saturation at 2^48-1, to one theta bin of the total histogram and of the
// closed, transition or open sector histogram chosen by its azimuth. A read
// item returns one bin of one histogram. Every item yields exactly one result
// item. The histograms live in two single-port-write, registered-read RAMs;
// an item is taken in the idle state, which issues the RAM read, and the
// lookup state then modifies, writes back and registers the result, so the
// block takes no new item until it is through with the last; the lookup
// state holds while an earlier result still waits at the output. After reset
// the block clears both RAMs one entry per cycle, sweeping all 3 * NUM_BINS
// sector addresses (1500 at the default bin count); input items are held off
// during the clearing while configuration writes are taken at any time.
module sector_binned_hit_histogrammer_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  shbh_hit_if.sink     hit_i,
  shbh_res_if.source   res_o,
  shbh_cfg_if.sink     cfg_i
);

  shbh_pkg::state_e state_q, state_d;

  shbh_pkg::cfg_t cfg_q;
  shbh_pkg::ctx_t ctx_now, ctx_q;

  logic [shbh_pkg::SADDR_W-1:0] clr_q, clr_d;
  logic                         clr_done;
  logic                         clr_tot;

  logic hit_accept;
  logic out_free;
  logic load_out;
  logic write_back;

  // RAM ports.
  logic                          tot_we, sec_we;
  logic [shbh_pkg::BIN_W-1:0]    tot_waddr;
  logic [shbh_pkg::SADDR_W-1:0]  sec_waddr;
  logic [shbh_pkg::ACC_W-1:0]    tot_wdata, sec_wdata;
  logic [shbh_pkg::ACC_W-1:0]    tot_rdata, sec_rdata;
  logic [shbh_pkg::ACC_W-1:0]    tot_sum, sec_sum;
  logic [shbh_pkg::ACC_W:0]      tot_wide, sec_wide;

  // Result register.
  logic                          out_valid_q, out_valid_d;
  logic                          out_accepted_q;
  logic [1:0]                    out_sector_q;
  logic [shbh_pkg::RBIN_W-1:0]   out_bin_q;
  logic [shbh_pkg::ACC_W-1:0]    out_value_q;
  logic [shbh_pkg::ACC_W-1:0]    read_value;

  // Configuration registers: writes are always taken, unknown indexes ignored.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.detector_match <= shbh_pkg::DET_RESET;
      cfg_q.energy_minimum <= shbh_pkg::ENERGY_RESET;
      cfg_q.radius_minimum <= shbh_pkg::RADIUS_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        shbh_pkg::CFG_DETECTOR: cfg_q.detector_match <= shbh_pkg::DET_W'(cfg_i.data);
        shbh_pkg::CFG_ENERGY:   cfg_q.energy_minimum <= cfg_i.data;
        shbh_pkg::CFG_RADIUS:   cfg_q.radius_minimum <= cfg_i.data;
        default: ;
      endcase
    end
  end

  shbh_classify u_classify (
    .cfg_i             (cfg_q),
    .op_i              (hit_i.op),
    .detector_number_i (hit_i.detector_number),
    .hit_energy_i      (hit_i.hit_energy),
    .hit_radius_i      (hit_i.hit_radius),
    .hit_azimuth_i     (hit_i.hit_azimuth),
    .scatter_angle_i   (hit_i.scatter_angle),
    .hit_weight_i      (hit_i.hit_weight),
    .read_bin_i        (hit_i.read_bin),
    .read_histogram_i  (hit_i.read_histogram),
    .ctx_o             (ctx_now)
  );

  // The output register is free when empty or being emptied this cycle.
  assign out_free   = !out_valid_q || res_o.ready;
  assign hit_accept = hit_i.valid && hit_i.ready;
  assign clr_done   = clr_q == shbh_pkg::SADDR_W'(shbh_pkg::SEC_DEPTH - 1);
  assign clr_tot    = 32'(clr_q) < 32'(shbh_pkg::NUM_BINS);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      shbh_pkg::ST_CLEAR: begin
        if (clr_done) state_d = shbh_pkg::ST_IDLE;
      end
      shbh_pkg::ST_IDLE: begin
        if (hit_i.valid) state_d = shbh_pkg::ST_LOOKUP;
      end
      shbh_pkg::ST_LOOKUP: begin
        if (out_free) state_d = shbh_pkg::ST_IDLE;
      end
      default: state_d = shbh_pkg::ST_CLEAR;
    endcase
  end

  // State outputs. The lookup cycle holds until the result register frees up;
  // the RAM read data stays put meanwhile since no new read is issued, and the
  // write-back happens only for a passing item, once, in the cycle the result is loaded.
  always_comb begin
    hit_i.ready = 1'b0;
    load_out    = 1'b0;
    write_back  = 1'b0;
    clr_d       = clr_q;
    case (state_q)
      shbh_pkg::ST_CLEAR: begin
        clr_d = clr_q + shbh_pkg::SADDR_W'(1);
      end
      shbh_pkg::ST_IDLE: begin
        hit_i.ready = 1'b1;
      end
      shbh_pkg::ST_LOOKUP: begin
        load_out   = out_free;
        write_back = out_free && ctx_q.pass;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= shbh_pkg::ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit_accept) begin
      ctx_q <= ctx_now;
    end
  end

  // Saturating accumulation of the read-back bins.
  assign tot_wide = {1'b0, tot_rdata} + (shbh_pkg::ACC_W + 1)'(ctx_q.weight);
  assign sec_wide = {1'b0, sec_rdata} + (shbh_pkg::ACC_W + 1)'(ctx_q.weight);
  assign tot_sum  = tot_wide[shbh_pkg::ACC_W] ? shbh_pkg::ACC_MAX : tot_wide[shbh_pkg::ACC_W-1:0];
  assign sec_sum  = sec_wide[shbh_pkg::ACC_W] ? shbh_pkg::ACC_MAX : sec_wide[shbh_pkg::ACC_W-1:0];

  // During the clearing pass the RAM write ports sweep the address range.
  always_comb begin
    if (state_q == shbh_pkg::ST_CLEAR) begin
      tot_we    = clr_tot;
      tot_waddr = shbh_pkg::BIN_W'(clr_q);
      tot_wdata = '0;
      sec_we    = 1'b1;
      sec_waddr = clr_q;
      sec_wdata = '0;
    end else begin
      tot_we    = write_back;
      tot_waddr = ctx_q.taddr;
      tot_wdata = tot_sum;
      sec_we    = write_back;
      sec_waddr = ctx_q.saddr;
      sec_wdata = sec_sum;
    end
  end

  shbh_ram #(
    .WIDTH (shbh_pkg::ACC_W),
    .DEPTH (shbh_pkg::NUM_BINS)
  ) u_total_ram (
    .clk_i   (clk_i),
    .we_i    (tot_we),
    .waddr_i (tot_waddr),
    .wdata_i (tot_wdata),
    .re_i    (hit_accept),
    .raddr_i (ctx_now.taddr),
    .rdata_o (tot_rdata)
  );

  shbh_ram #(
    .WIDTH (shbh_pkg::ACC_W),
    .DEPTH (shbh_pkg::SEC_DEPTH)
  ) u_sector_ram (
    .clk_i   (clk_i),
    .we_i    (sec_we),
    .waddr_i (sec_waddr),
    .wdata_i (sec_wdata),
    .re_i    (hit_accept),
    .raddr_i (ctx_now.saddr),
    .rdata_o (sec_rdata)
  );

  // A read item out of bin range returns zero.
  always_comb begin
    if (!ctx_q.range_ok) begin
      read_value = '0;
    end else if (ctx_q.read_histogram == shbh_pkg::HIST_TOTAL) begin
      read_value = tot_rdata;
    end else begin
      read_value = sec_rdata;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (ctx_q.op == shbh_pkg::OP_READ) begin
        out_accepted_q <= 1'b0;
        out_sector_q   <= shbh_pkg::SECTOR_CLOSED;
        out_bin_q      <= ctx_q.read_bin;
        out_value_q    <= read_value;
      end else begin
        out_accepted_q <= ctx_q.pass;
        out_sector_q   <= ctx_q.pass ? ctx_q.sector : shbh_pkg::SECTOR_CLOSED;
        out_bin_q      <= shbh_pkg::RBIN_W'(ctx_q.bin);
        out_value_q    <= '0;
      end
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.accepted     = out_accepted_q;
  assign res_o.sector_class = out_sector_q;
  assign res_o.bin_number   = out_bin_q;
  assign res_o.bin_value    = out_value_q;

endmodule

### rtl/shbh_ram.sv
module shbh_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/shbh_classify.sv
module shbh_classify (
  input  shbh_pkg::cfg_t                 cfg_i,
  input  logic                           op_i,
  input  logic [shbh_pkg::DET_W-1:0]     detector_number_i,
  input  logic [shbh_pkg::VAL16_W-1:0]   hit_energy_i,
  input  logic [shbh_pkg::VAL16_W-1:0]   hit_radius_i,
  input  logic [15:0]                    hit_azimuth_i,
  input  logic [shbh_pkg::VAL16_W-1:0]   scatter_angle_i,
  input  logic [shbh_pkg::WEIGHT_W-1:0]  hit_weight_i,
  input  logic [shbh_pkg::RBIN_W-1:0]    read_bin_i,
  input  logic [1:0]                     read_histogram_i,
  output shbh_pkg::ctx_t                 ctx_o
);

  logic [shbh_pkg::PROD_W-1:0]  prod;
  logic [shbh_pkg::BIN_W-1:0]   bin;
  logic [shbh_pkg::SEC_W-1:0]   pos;
  logic [1:0]                   sector;
  logic                         pass;
  logic                         range_ok;
  logic [shbh_pkg::BIN_W-1:0]   rbin;
  logic [1:0]                   rsec;
  logic [1:0]                   sel_sec;
  logic [shbh_pkg::BIN_W-1:0]   sel_bin;

  // Theta bin: the product is below NUM_BINS * 2^16, so the top bits always fit.
  assign prod = shbh_pkg::PROD_W'(scatter_angle_i) * shbh_pkg::PROD_W'(shbh_pkg::NUM_BINS);
  assign bin  = shbh_pkg::BIN_W'(prod[shbh_pkg::PROD_W-1:16]);

  // Both 57344 and 65536 are multiples of 8192, so the low bits give the
  // position within one seventh of a turn whatever the sign.
  assign pos = hit_azimuth_i[shbh_pkg::SEC_W-1:0];

  always_comb begin
    if (pos < shbh_pkg::SEC_EDGE_A) begin
      sector = shbh_pkg::SECTOR_CLOSED;
    end else if (pos < shbh_pkg::SEC_EDGE_B) begin
      sector = shbh_pkg::SECTOR_TRANS;
    end else if (pos < shbh_pkg::SEC_EDGE_C) begin
      sector = shbh_pkg::SECTOR_OPEN;
    end else if (pos < shbh_pkg::SEC_EDGE_D) begin
      sector = shbh_pkg::SECTOR_TRANS;
    end else begin
      sector = shbh_pkg::SECTOR_CLOSED;
    end
  end

  assign pass = (op_i == shbh_pkg::OP_RECORD) &&
                (detector_number_i == cfg_i.detector_match) &&
                (hit_energy_i > cfg_i.energy_minimum) &&
                (hit_radius_i > cfg_i.radius_minimum);

  assign range_ok = 32'(read_bin_i) < 32'(shbh_pkg::NUM_BINS);
  assign rbin     = range_ok ? shbh_pkg::BIN_W'(read_bin_i) : '0;
  assign rsec     = (read_histogram_i == shbh_pkg::HIST_TOTAL) ? 2'd0 : read_histogram_i - 2'd1;

  assign sel_sec = (op_i == shbh_pkg::OP_READ) ? rsec : sector;
  assign sel_bin = (op_i == shbh_pkg::OP_READ) ? rbin : bin;

  always_comb begin
    ctx_o.op             = op_i;
    ctx_o.pass           = pass;
    ctx_o.sector         = sector;
    ctx_o.bin            = bin;
    ctx_o.read_bin       = read_bin_i;
    ctx_o.range_ok       = range_ok;
    ctx_o.read_histogram = read_histogram_i;
    ctx_o.weight         = hit_weight_i;
    ctx_o.taddr          = sel_bin;
    ctx_o.saddr          = shbh_pkg::SADDR_W'(sel_sec) * shbh_pkg::SADDR_W'(shbh_pkg::NUM_BINS)
                           + shbh_pkg::SADDR_W'(sel_bin);
  end

endmodule

### rtl/shbh_checker.sv
module shbh_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          hit_valid_i,
  input logic                          hit_ready_i,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic                          res_accepted_i,
  input logic [1:0]                    res_sector_class_i,
  input logic [shbh_pkg::ACC_W-1:0]    res_bin_value_i
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result item withdrawn before it was taken");

  // The block works on one item at a time: no item is taken right after one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_valid_i && hit_ready_i |=> !hit_ready_i)
    else $error("input item taken while another is in flight");

  // A recorded hit reports no bin value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_accepted_i |-> res_bin_value_i == '0)
    else $error("accepted hit carries a nonzero bin value");

  // Only an accepted hit carries a sector, and never the unused code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_accepted_i || res_sector_class_i == shbh_pkg::SECTOR_CLOSED) &&
                    res_sector_class_i <= shbh_pkg::SECTOR_OPEN)
    else $error("sector class inconsistent with the accepted flag");

endmodule

bind sector_binned_hit_histogrammer_unit shbh_checker u_shbh_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .hit_valid_i        (hit_i.valid),
  .hit_ready_i        (hit_i.ready),
  .res_valid_i        (res_o.valid),
  .res_ready_i        (res_o.ready),
  .res_accepted_i     (res_o.accepted),
  .res_sector_class_i (res_o.sector_class),
  .res_bin_value_i    (res_o.bin_value)
);
